[hdl/hkix_pkg.sv]
// hkix_pkg: shared constants, codes and types of the hashed key index
// depends on nothing; used by every module of the block
`timescale 1ns / 1ps

package hkix_pkg;

   localparam int SLOT_COUNT    = 1024;
   localparam int SLOT_W        = $clog2(SLOT_COUNT);
   localparam int MAX_KEY_BYTES = 32;
   localparam int KEY_CNT_W     = $clog2(MAX_KEY_BYTES + 2);
   localparam int KEY_LEN_W     = $clog2(MAX_KEY_BYTES + 1);
   localparam int KEY_BITS      = MAX_KEY_BYTES * 8;

   localparam int OFF_W   = 29;
   localparam int PL_W    = 29;
   localparam int CUR_W   = 30;
   localparam int ARENA_W = 29;
   localparam int LIMIT_W = 8;
   localparam int ROFF_W  = 28;

   localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME_LO = 64'h1b3;
   localparam int          FNV_SHIFT    = 40;

   localparam logic [CUR_W-1:0]   DATA_START = CUR_W'(4096 + SLOT_COUNT * 8);
   localparam logic [ARENA_W-1:0] ARENA_CAP  = ARENA_W'(256 * 1024 * 1024);
   localparam logic [CUR_W-1:0]   CURSOR_MAX = {CUR_W{1'b1}};
   localparam logic [CUR_W-1:0]   HDR_BYTES  = CUR_W'(16);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(128);

   typedef enum logic {
      CSR_ARENA_SIZE  = 1'b0,
      CSR_PROBE_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_HIT        = 3'd0,
      ST_MISS       = 3'd1,
      ST_INSERTED   = 3'd2,
      ST_PRESENT    = 3'd3,
      ST_ARENA_FULL = 3'd4,
      ST_CONGESTED  = 3'd5,
      ST_TOO_LONG   = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_SLOT,
      SRC_NEW
   } src_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_PROBE,
      S_CHK1,
      S_CHK2,
      S_ALLOC,
      S_DECIDE,
      S_OUT
   } fsm_type;

   typedef struct packed {
      logic [OFF_W-1:0]     off;
      logic [KEY_LEN_W-1:0] klen;
      logic                 kind;
      logic [PL_W-1:0]      pl;
   } entry_type;

   typedef struct packed {
      logic       clr_wr;
      logic       byte_en;
      logic       chk1;
      logic       step;
      logic       alloc;
      logic       commit;
      logic       ins_wr;
      logic       res_en;
      status_type res_status;
      src_type    res_src;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic too_long;
      logic limit_hit;
      logic slot_empty;
      logic slot_readable;
      logic slot_match;
      logic arena_full;
      logic mode;
      logic out_free;
   } stat_type;

endpackage

[hdl/hashed_key_index_with_bump_alloc_core.sv]
// sequence: S_IDLE takes key bytes, S_START checks the length, then each slot
// examined in the probe walk passes S_PROBE, S_CHK1 and S_CHK2 (one read port
// of the slot memory); the probe limit ends the walk in S_PROBE, a publish
// allocates in S_ALLOC and S_DECIDE, and S_OUT loads the result register
// throughput: one key at a time, bytes back to back within a key
// reset: synchronous; a clearing pass then empties the slot table with
// req_ready low, configuration writes are taken throughout
`timescale 1ns / 1ps

module hashed_key_index_with_bump_alloc_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [hkix_pkg::ARENA_W-1:0]  csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [7:0]                    req_key_byte,
   input  logic                          req_key_last,
   input  logic                          req_record_kind,
   input  logic [hkix_pkg::PL_W-1:0]     req_payload_len,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [hkix_pkg::ROFF_W-1:0]   rsp_record_offset,
   output logic                          rsp_found_kind,
   output logic [hkix_pkg::PL_W-1:0]     rsp_found_payload_len
);
   import hkix_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   hkix_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_key_last (req_key_last),
      .req_ready    (req_ready),
      .stat         (stat),
      .cmd          (cmd)
   );

   hkix_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_we                (csr_valid & csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_mode              (req_mode),
      .req_key_byte          (req_key_byte),
      .req_key_last          (req_key_last),
      .req_record_kind       (req_record_kind),
      .req_payload_len       (req_payload_len),
      .cmd                   (cmd),
      .stat                  (stat),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_record_offset     (rsp_record_offset),
      .rsp_found_kind        (rsp_found_kind),
      .rsp_found_payload_len (rsp_found_payload_len)
   );

endmodule

[hdl/hkix_ctrl.sv]
// hkix_ctrl: sequencer for key intake, probe walk, allocation and result
// depends on hkix_pkg; drives the datapath hkix_dp through cmd_type
`timescale 1ns / 1ps

module hkix_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_key_last,
   output logic              req_ready,
   input  hkix_pkg::stat_type stat,
   output hkix_pkg::cmd_type  cmd
);
   import hkix_pkg::*;

   fsm_type state_ff, state_in;
   logic    ins_ok_ff, ins_ok_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         ins_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ins_ok_ff <= ins_ok_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ins_ok_in = ins_ok_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.byte_en = req_valid;
            if (req_valid && req_key_last) state_in = S_START;
         end
         S_START: begin
            if (stat.too_long) begin
               cmd.res_en     = 1'b1;
               cmd.res_status = ST_TOO_LONG;
               cmd.res_src    = SRC_ZERO;
               state_in       = S_OUT;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (stat.limit_hit) begin
               if (stat.mode) begin
                  ins_ok_in = 1'b0;
                  state_in  = S_ALLOC;
               end else begin
                  cmd.res_en     = 1'b1;
                  cmd.res_status = ST_MISS;
                  cmd.res_src    = SRC_ZERO;
                  state_in       = S_OUT;
               end
            end else begin
               state_in = S_CHK1;
            end
         end
         S_CHK1: begin
            cmd.chk1 = 1'b1;
            state_in = S_CHK2;
         end
         S_CHK2: begin
            if (stat.slot_empty || !stat.slot_readable) begin
               if (stat.mode) begin
                  ins_ok_in = stat.slot_empty;
                  state_in  = S_ALLOC;
               end else begin
                  cmd.res_en     = 1'b1;
                  cmd.res_status = ST_MISS;
                  cmd.res_src    = SRC_ZERO;
                  state_in       = S_OUT;
               end
            end else if (stat.slot_match) begin
               cmd.res_en     = 1'b1;
               cmd.res_status = stat.mode ? ST_PRESENT : ST_HIT;
               cmd.res_src    = SRC_SLOT;
               state_in       = S_OUT;
            end else begin
               cmd.step = 1'b1;
               state_in = S_PROBE;
            end
         end
         S_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.commit = 1'b1;
            cmd.res_en = 1'b1;
            if (stat.arena_full) begin
               cmd.res_status = ST_ARENA_FULL;
               cmd.res_src    = SRC_ZERO;
            end else if (ins_ok_ff) begin
               cmd.ins_wr     = 1'b1;
               cmd.res_status = ST_INSERTED;
               cmd.res_src    = SRC_NEW;
            end else begin
               cmd.res_status = ST_CONGESTED;
               cmd.res_src    = SRC_ZERO;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[hdl/hkix_dp.sv]
// hkix_dp: hash, key buffer, slot memories, probe checks, bump allocator
// and result register; depends on hkix_pkg, commanded by hkix_ctrl
`timescale 1ns / 1ps

module hkix_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [hkix_pkg::ARENA_W-1:0]  csr_wdata,
   input  logic                          req_mode,
   input  logic [7:0]                    req_key_byte,
   input  logic                          req_key_last,
   input  logic                          req_record_kind,
   input  logic [hkix_pkg::PL_W-1:0]     req_payload_len,
   input  hkix_pkg::cmd_type             cmd,
   output hkix_pkg::stat_type            stat,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [hkix_pkg::ROFF_W-1:0]   rsp_record_offset,
   output logic                          rsp_found_kind,
   output logic [hkix_pkg::PL_W-1:0]     rsp_found_payload_len
);
   import hkix_pkg::*;

   localparam int SUM_W = SLOT_W + LIMIT_W;

   logic [ARENA_W-1:0]   arena_size_ff;
   logic [LIMIT_W-1:0]   probe_limit_ff;
   logic [63:0]          hash_ff;
   logic [KEY_CNT_W-1:0] cnt_ff;
   logic [KEY_BITS-1:0]  keybuf_ff;
   logic [SLOT_W-1:0]    base_ff;
   logic [KEY_CNT_W-1:0] len_ff;
   logic                 mode_ff;
   logic                 kind_ff;
   logic [PL_W-1:0]      pl_ff;
   logic [LIMIT_W-1:0]   p_ff;
   logic [SLOT_W-1:0]    clr_cnt_ff;
   entry_type            ent_rd_ff;
   logic [KEY_BITS-1:0]  key_rd_ff;
   entry_type            ent_ff;
   logic                 empty_ff;
   logic                 ok1_ff;
   logic [CUR_W-1:0]     ps_ff;
   logic                 match_ff;
   logic [CUR_W-1:0]     rec_ff;
   logic [CUR_W-1:0]     cursor_ff;
   status_type           res_status_ff;
   logic [ROFF_W-1:0]    res_off_ff;
   logic                 res_kind_ff;
   logic [PL_W-1:0]      res_pl_ff;
   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic [ROFF_W-1:0]    rsp_off_ff;
   logic                 rsp_kind_ff;
   logic [PL_W-1:0]      rsp_pl_ff;

   entry_type            ent_mem [SLOT_COUNT];
   logic [KEY_BITS-1:0]  key_mem [SLOT_COUNT];

   logic [ARENA_W-1:0]   arena_end;
   logic [CUR_W-1:0]     end_c;
   logic [63:0]          hx;
   logic [63:0]          hash_in;
   logic [KEY_CNT_W-1:0] cnt_in;
   logic [SUM_W-1:0]     idx_sum;
   logic [SLOT_W-1:0]    slot_idx;
   logic [CUR_W-1:0]     off_c;
   logic                 ok1_in;
   logic [CUR_W-1:0]     ps_raw;
   logic [CUR_W-1:0]     ps_in;
   logic [MAX_KEY_BYTES-1:0] byte_eq;
   logic                 match_in;
   logic [7:0]           hdr8;
   logic [CUR_W-1:0]     rec_in;
   logic [CUR_W:0]       rec_al;
   logic [CUR_W:0]       next_c;
   logic [CUR_W-1:0]     cursor_in;
   logic                 arena_full;
   logic                 readable;
   entry_type            ins_ent;

   always_comb begin
      arena_end = (arena_size_ff > ARENA_CAP) ? ARENA_CAP : arena_size_ff;
      end_c     = CUR_W'(arena_end);
      hx        = hash_ff ^ 64'(req_key_byte);
      hash_in   = (hx << FNV_SHIFT) + 64'(hx * FNV_PRIME_LO);
      cnt_in    = (cnt_ff <= KEY_CNT_W'(MAX_KEY_BYTES)) ? cnt_ff + 1'b1 : cnt_ff;
      idx_sum   = SUM_W'(base_ff) + SUM_W'(p_ff);
      slot_idx  = idx_sum[SLOT_W-1:0];

      off_c  = CUR_W'(ent_rd_ff.off);
      ok1_in = (off_c >= DATA_START) && (off_c + HDR_BYTES <= end_c);
      ps_raw = off_c + HDR_BYTES + CUR_W'(ent_rd_ff.klen) + CUR_W'(7);
      ps_in  = {ps_raw[CUR_W-1:3], 3'b000};
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
         byte_eq[i] = (KEY_CNT_W'(i) >= len_ff) ||
                      (key_rd_ff[i*8 +: 8] == keybuf_ff[i*8 +: 8]);
      end
      match_in = (ent_rd_ff.klen == len_ff[KEY_LEN_W-1:0]) && (&byte_eq);

      readable = ok1_ff && (ps_ff <= end_c) && (CUR_W'(ent_ff.pl) <= end_c - ps_ff);

      hdr8   = (8'(len_ff) + 8'd23) & 8'hf8;
      rec_in = CUR_W'(hdr8) + CUR_W'(pl_ff);
      rec_al = ({1'b0, rec_ff} + (CUR_W+1)'(7)) & ~((CUR_W+1)'(7));
      next_c = {1'b0, cursor_ff} + rec_al;
      cursor_in  = (next_c > {1'b0, CURSOR_MAX}) ? CURSOR_MAX : next_c[CUR_W-1:0];
      arena_full = (cursor_ff > end_c) || (rec_ff > end_c - cursor_ff);

      ins_ent.off  = cursor_ff[OFF_W-1:0];
      ins_ent.klen = len_ff[KEY_LEN_W-1:0];
      ins_ent.kind = kind_ff;
      ins_ent.pl   = pl_ff;

      stat.clr_last      = (clr_cnt_ff == SLOT_W'(SLOT_COUNT - 1));
      stat.too_long      = (len_ff > KEY_CNT_W'(MAX_KEY_BYTES));
      stat.limit_hit     = (p_ff == probe_limit_ff);
      stat.slot_empty    = empty_ff;
      stat.slot_readable = readable;
      stat.slot_match    = match_ff;
      stat.arena_full    = arena_full;
      stat.mode          = mode_ff;
      stat.out_free      = !rsp_valid_ff || rsp_ready;
   end

   // slot memories
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         ent_mem[clr_cnt_ff] <= '0;
      end else if (cmd.ins_wr) begin
         ent_mem[slot_idx] <= ins_ent;
         key_mem[slot_idx] <= keybuf_ff;
      end
      ent_rd_ff <= ent_mem[slot_idx];
      key_rd_ff <= key_mem[slot_idx];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         arena_size_ff  <= ARENA_CAP;
         probe_limit_ff <= LIMIT_RESET;
         hash_ff        <= FNV_BASIS;
         cnt_ff         <= '0;
         clr_cnt_ff     <= '0;
         cursor_ff      <= DATA_START;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ARENA_SIZE:  arena_size_ff  <= csr_wdata;
               CSR_PROBE_LIMIT: probe_limit_ff <= csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.byte_en) begin
            hash_ff <= req_key_last ? FNV_BASIS : hash_in;
            cnt_ff  <= req_key_last ? '0 : cnt_in;
         end
         if (cmd.clr_wr) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.commit) cursor_ff <= cursor_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.byte_en) begin
         for (int i = 0; i < MAX_KEY_BYTES; i++) begin
            if (cnt_ff == KEY_CNT_W'(i)) keybuf_ff[i*8 +: 8] <= req_key_byte;
         end
         if (req_key_last) begin
            base_ff <= hash_in[SLOT_W-1:0];
            len_ff  <= cnt_in;
            mode_ff <= req_mode;
            kind_ff <= req_record_kind;
            pl_ff   <= req_payload_len;
            p_ff    <= '0;
         end
      end
      if (cmd.step) p_ff <= p_ff + 1'b1;
      if (cmd.chk1) begin
         ent_ff   <= ent_rd_ff;
         empty_ff <= (ent_rd_ff.off == '0);
         ok1_ff   <= ok1_in;
         ps_ff    <= ps_in;
         match_ff <= match_in;
      end
      if (cmd.alloc) rec_ff <= rec_in;
      if (cmd.res_en) begin
         res_status_ff <= cmd.res_status;
         case (cmd.res_src)
            SRC_SLOT: begin
               res_off_ff  <= ent_ff.off[ROFF_W-1:0];
               res_kind_ff <= ent_ff.kind;
               res_pl_ff   <= ent_ff.pl;
            end
            SRC_NEW: begin
               res_off_ff  <= cursor_ff[ROFF_W-1:0];
               res_kind_ff <= kind_ff;
               res_pl_ff   <= pl_ff;
            end
            default: begin
               res_off_ff  <= '0;
               res_kind_ff <= 1'b0;
               res_pl_ff   <= '0;
            end
         endcase
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_off_ff    <= res_off_ff;
         rsp_kind_ff   <= res_kind_ff;
         rsp_pl_ff     <= res_pl_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_record_offset     = rsp_off_ff;
   assign rsp_found_kind        = rsp_kind_ff;
   assign rsp_found_payload_len = rsp_pl_ff;

endmodule

[hdl/hkix_chk.sv]
// hkix_chk: port level checks of the hashed key index, bound to the top
// depends on hkix_pkg and hashed_key_index_with_bump_alloc_core
`timescale 1ns / 1ps

module hkix_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [2:0]                    rsp_status,
   input logic [hkix_pkg::ROFF_W-1:0]   rsp_record_offset,
   input logic                          rsp_found_kind,
   input logic [hkix_pkg::PL_W-1:0]     rsp_found_payload_len
);
   import hkix_pkg::*;

   // word held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped");

   // error outcomes carry zero fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_MISS || rsp_status == ST_ARENA_FULL ||
                    rsp_status == ST_CONGESTED || rsp_status == ST_TOO_LONG)
      |-> rsp_record_offset == '0 && !rsp_found_kind && rsp_found_payload_len == '0)
      else $error("error word with nonzero fields");

   // new records are 8-aligned and past the index area
   a_ins_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INSERTED
      |-> rsp_record_offset[2:0] == 3'b000 &&
          CUR_W'(rsp_record_offset) >= DATA_START)
      else $error("bad inserted offset");

   // clearing pass blocks input right after reset
   a_clear_busy: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("input taken during clearing pass");

endmodule

bind hashed_key_index_with_bump_alloc_core hkix_chk u_hkix_chk (.*);
